// ----- sv/bfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bfc_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned P_WORDS   = 18;
    localparam int unsigned S_WORDS   = 1024;
    localparam int unsigned S_ADDR_W  = $clog2(S_WORDS);
    localparam int unsigned ROUNDS    = 16;
    localparam int unsigned KEY_REGS  = 4;

    localparam logic [WORD_W-1:0] SEED = 32'hDEADBEEF;

    // Generator walk covers P then all S words
    localparam logic [10:0] GEN_LAST   = 11'(P_WORDS + S_WORDS - 1);
    // Chained encryptions: nine for P, 512 for S
    localparam logic [9:0]  CHAIN_P    = 10'(P_WORDS / 2);
    localparam logic [9:0]  CHAIN_LAST = 10'(P_WORDS / 2 + S_WORDS / 2 - 1);

    typedef enum logic [1:0] {
        FUNC_REKEY   = 2'd0,
        FUNC_ENCRYPT = 2'd1,
        FUNC_DECRYPT = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_RND_P,
        ST_RND_F,
        ST_FIN,
        ST_WR_LO,
        ST_WR_HI,
        ST_OUT
    } state_t;

    function automatic logic [WORD_W-1:0] rng_next(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] t;
        begin
            t = x ^ (x << 13);
            t = t ^ (t >> 17);
            t = t ^ (t << 5);
            return t;
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/bfc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bfc_ram #(
    parameter int unsigned WIDTH = bfc_pkg::WORD_W,
    parameter int unsigned DEPTH = bfc_pkg::S_WORDS
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/blowfish_block_cipher_unit.sv -----
// Encrypt/decrypt: 16 rounds (P xor, then four S-box reads through the single
// read port of the S-box RAM), plus whitening and output.
// Rekey: a generator walk over all P and S words, then 521 chained encryptions,
// each S-box pair written as two RAM words after its encryption.
// One item at a time; input stalls until the result is registered.
// Async active-low reset clears control state and the keyed flag; tables hold garbage.
`timescale 1ns / 1ps
`default_nettype none
module blowfish_block_cipher_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] block_left,
    input  wire logic [31:0] block_right,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      result_first,
    output logic [31:0]      result_second,
    output logic             keyed,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int unsigned AW = bfc_pkg::S_ADDR_W;

    bfc_pkg::state_t state_reg, state_next;
    logic [10:0] gen_cnt_reg, gen_cnt_next;
    logic [9:0]  chain_reg, chain_next;
    logic [3:0]  rnd_reg, rnd_next;
    logic [2:0]  sub_reg, sub_next;
    logic [31:0] xl_reg, xl_next, xr_reg, xr_next, h_reg, h_next, rng_reg, rng_next;
    logic        dec_reg, dec_next, rekey_reg, rekey_next, zero_reg, zero_next;
    logic        keyed_reg, keyed_next, out_valid_reg, out_valid_next;
    logic        keyed_out_reg, keyed_out_next;
    logic [31:0] first_reg, first_next, second_reg, second_next;
    logic [63:0] key_reg [bfc_pkg::KEY_REGS];
    logic [31:0] p_reg [bfc_pkg::P_WORDS];

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    logic        p_we_one, p_we_pair;
    logic [4:0]  p_widx;
    logic [31:0] p_wdata;
    logic [4:0]  pidx;
    logic [31:0] rng_n, key_word, fin_first, fin_second;
    logic [10:0] s_gen_addr;
    logic [9:0]  s_chain_idx;
    logic [7:0]  sbyte;
    logic        accept;

    bfc_ram #(
        .WIDTH(bfc_pkg::WORD_W),
        .DEPTH(bfc_pkg::S_WORDS)
    ) u_sbox (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_stall      = (state_reg != bfc_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign result_first  = first_reg;
    assign result_second = second_reg;
    assign keyed         = keyed_out_reg;
    assign accept        = in_valid && !in_stall;

    assign rng_n       = bfc_pkg::rng_next(rng_reg);
    assign key_word    = gen_cnt_reg[0] ? key_reg[gen_cnt_reg[2:1]][63:32]
                                        : key_reg[gen_cnt_reg[2:1]][31:0];
    assign s_gen_addr  = gen_cnt_reg - 11'(bfc_pkg::P_WORDS);
    assign s_chain_idx = chain_reg - bfc_pkg::CHAIN_P;
    assign pidx        = dec_reg ? (5'(bfc_pkg::P_WORDS - 1) - {1'b0, rnd_reg})
                                 : {1'b0, rnd_reg};
    assign fin_first   = xr_reg ^ (dec_reg ? p_reg[0] : p_reg[17]);
    assign fin_second  = xl_reg ^ (dec_reg ? p_reg[1] : p_reg[16]);

    always_comb
    begin
        case (sub_reg[1:0])
            2'd0:    sbyte = xl_reg[31:24];
            2'd1:    sbyte = xl_reg[23:16];
            2'd2:    sbyte = xl_reg[15:8];
            default: sbyte = xl_reg[7:0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        gen_cnt_next   = gen_cnt_reg;
        chain_next     = chain_reg;
        rnd_next       = rnd_reg;
        sub_next       = sub_reg;
        xl_next        = xl_reg;
        xr_next        = xr_reg;
        h_next         = h_reg;
        rng_next       = rng_reg;
        dec_next       = dec_reg;
        rekey_next     = rekey_reg;
        zero_next      = zero_reg;
        keyed_next     = keyed_reg;
        keyed_out_next = keyed_out_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = s_gen_addr[AW-1:0];
        ram_wdata      = rng_n;
        ram_raddr      = {sub_reg[1:0], sbyte};
        p_we_one       = 1'b0;
        p_we_pair      = 1'b0;
        p_widx         = gen_cnt_reg[4:0];
        p_wdata        = rng_n ^ key_word;

        case (state_reg)
            bfc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rnd_next  = '0;
                    sub_next  = '0;
                    xl_next   = block_left;
                    xr_next   = block_right;
                    dec_next  = (func == bfc_pkg::FUNC_DECRYPT);
                    rekey_next = 1'b0;
                    zero_next = 1'b0;
                    if (func == bfc_pkg::FUNC_REKEY)
                    begin
                        rekey_next   = 1'b1;
                        zero_next    = 1'b1;
                        dec_next     = 1'b0;
                        rng_next     = bfc_pkg::SEED;
                        gen_cnt_next = '0;
                        chain_next   = '0;
                        xl_next      = '0;
                        xr_next      = '0;
                        state_next   = bfc_pkg::ST_GEN;
                    end
                    else if (keyed_reg && (func == bfc_pkg::FUNC_ENCRYPT ||
                                           func == bfc_pkg::FUNC_DECRYPT))
                    begin
                        state_next = bfc_pkg::ST_RND_P;
                    end
                    else
                    begin
                        zero_next  = 1'b1;
                        state_next = bfc_pkg::ST_OUT;
                    end
                end
            end
            bfc_pkg::ST_GEN:
            begin
                rng_next = rng_n;
                if (gen_cnt_reg < 11'(bfc_pkg::P_WORDS))
                begin
                    p_we_one = 1'b1;
                end
                else
                begin
                    ram_we = 1'b1;
                end
                if (gen_cnt_reg == bfc_pkg::GEN_LAST)
                begin
                    rnd_next   = '0;
                    state_next = bfc_pkg::ST_RND_P;
                end
                else
                begin
                    gen_cnt_next = gen_cnt_reg + 11'd1;
                end
            end
            bfc_pkg::ST_RND_P:
            begin
                xl_next    = xl_reg ^ p_reg[pidx];
                sub_next   = '0;
                state_next = bfc_pkg::ST_RND_F;
            end
            bfc_pkg::ST_RND_F:
            begin
                // read data arrives in the cycle after its address (registered RAM read)
                sub_next = sub_reg + 3'd1;
                case (sub_reg)
                    3'd1:    h_next = ram_rdata;
                    3'd2:    h_next = h_reg + ram_rdata;
                    3'd3:    h_next = h_reg ^ ram_rdata;
                    default: h_next = h_reg;
                endcase
                if (sub_reg == 3'd4)
                begin
                    xl_next = xr_reg ^ (h_reg + ram_rdata);
                    xr_next = xl_reg;
                    if (rnd_reg == 4'(bfc_pkg::ROUNDS - 1))
                    begin
                        state_next = bfc_pkg::ST_FIN;
                    end
                    else
                    begin
                        rnd_next   = rnd_reg + 4'd1;
                        state_next = bfc_pkg::ST_RND_P;
                    end
                end
            end
            bfc_pkg::ST_FIN:
            begin
                xl_next  = fin_first;
                xr_next  = fin_second;
                rnd_next = '0;
                if (!rekey_reg)
                begin
                    state_next = bfc_pkg::ST_OUT;
                end
                else if (chain_reg < bfc_pkg::CHAIN_P)
                begin
                    p_we_pair  = 1'b1;
                    chain_next = chain_reg + 10'd1;
                    state_next = bfc_pkg::ST_RND_P;
                end
                else
                begin
                    state_next = bfc_pkg::ST_WR_LO;
                end
            end
            bfc_pkg::ST_WR_LO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {s_chain_idx[AW-2:0], 1'b0};
                ram_wdata  = xl_reg;
                state_next = bfc_pkg::ST_WR_HI;
            end
            bfc_pkg::ST_WR_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = {s_chain_idx[AW-2:0], 1'b1};
                ram_wdata = xr_reg;
                if (chain_reg == bfc_pkg::CHAIN_LAST)
                begin
                    keyed_next = 1'b1;
                    state_next = bfc_pkg::ST_OUT;
                end
                else
                begin
                    chain_next = chain_reg + 10'd1;
                    state_next = bfc_pkg::ST_RND_P;
                end
            end
            bfc_pkg::ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    first_next     = zero_reg ? '0 : xl_reg;
                    second_next    = zero_reg ? '0 : xr_reg;
                    keyed_out_next = keyed_reg;
                    state_next     = bfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfc_pkg::ST_IDLE;
            keyed_reg     <= 1'b0;
            keyed_out_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rekey_reg     <= 1'b0;
            gen_cnt_reg   <= '0;
            chain_reg     <= '0;
            rnd_reg       <= '0;
            sub_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            keyed_reg     <= keyed_next;
            keyed_out_reg <= keyed_out_next;
            out_valid_reg <= out_valid_next;
            rekey_reg     <= rekey_next;
            gen_cnt_reg   <= gen_cnt_next;
            chain_reg     <= chain_next;
            rnd_reg       <= rnd_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xl_reg     <= xl_next;
        xr_reg     <= xr_next;
        h_reg      <= h_next;
        rng_reg    <= rng_next;
        dec_reg    <= dec_next;
        zero_reg   <= zero_next;
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bfc_pkg::KEY_REGS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we_one)
        begin
            p_reg[p_widx] <= p_wdata;
        end
        else if (p_we_pair)
        begin
            p_reg[{chain_reg[3:0], 1'b0}] <= fin_first;
            p_reg[{chain_reg[3:0], 1'b1}] <= fin_second;
        end
    end

`ifndef SYNTH
    a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        keyed_reg |=> keyed_reg)
        else $error("keyed flag dropped");

    a_ram_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == bfc_pkg::ST_GEN || state_reg == bfc_pkg::ST_WR_LO ||
                    state_reg == bfc_pkg::ST_WR_HI))
        else $error("S-box write outside key schedule");

    a_pidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfc_pkg::ST_RND_P) |-> (pidx < 5'(bfc_pkg::P_WORDS)))
        else $error("P index out of range");

    a_block_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfc_pkg::ST_RND_P && !rekey_reg) |-> keyed_reg)
        else $error("block operation started without a key");
`endif

endmodule
`default_nettype wire
